// ----- hw/rtl/ppw_pkg.sv -----
// Shared types and codes for the palette pixel window writer.
// Used by the front, queue, back and top-level modules.
`default_nettype none
package ppw_pkg;

  // input command codes
  localparam logic [1:0] CMD_PAL = 2'd0;
  localparam logic [1:0] CMD_WIN = 2'd1;
  localparam logic [1:0] CMD_PIX = 2'd2;

  // queued work kinds
  localparam logic [1:0] KIND_PAL = 2'd0;
  localparam logic [1:0] KIND_HDR = 2'd1;
  localparam logic [1:0] KIND_PIX = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DEPTH  = 2'd0;
  localparam logic [1:0] REG_COL_OP = 2'd1;
  localparam logic [1:0] REG_ROW_OP = 2'd2;
  localparam logic [1:0] REG_MEM_OP = 2'd3;

  localparam logic [2:0] DEPTH_DIRECT = 3'd4;
  localparam logic [7:0] COL_OP_RST   = 8'h2A;
  localparam logic [7:0] ROW_OP_RST   = 8'h2B;
  localparam logic [7:0] MEM_OP_RST   = 8'h2C;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int CNT_W       = 13;

  // header step positions of the command bytes
  localparam logic [3:0] HDR_COL_STEP  = 4'd0;
  localparam logic [3:0] HDR_ROW_STEP  = 4'd5;
  localparam logic [3:0] HDR_LAST_STEP = 4'd10;

  typedef struct packed {
    logic [2:0] depth;
    logic [7:0] col_op;
    logic [7:0] row_op;
    logic [7:0] mem_op;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  depth;
    logic        eol;
    logic        eow;
    logic [7:0]  pal_index;
    logic [15:0] color;
    logic [9:0]  x0;
    logic [9:0]  y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [7:0]  pbyte;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage
`default_nettype wire

// ----- hw/rtl/palette_pixel_window_writer_core.sv -----
// Top level of the palette pixel window writer: configuration registers and
// the front, queue and back instances. Depends on ppw_pkg and the ppw_* modules.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/stall   | command, palette, window, packed byte
//   out_    | output    | out_valid/stall  | link byte, is_data, eol, eow, last
//   cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// One link byte per cycle leaves the back end's sequencer while the output is not
// stalled: a window start yields 11 link bytes, a packed pixel byte 2 * 8/bpp
// (16 at 1 bpp), a direct byte one and a palette write none. The front takes a
// transaction per cycle until the four-entry queue fills. Palette reads are
// registered at the same edge as the output register. Reset restores the
// register defaults and empties the window.
`default_nettype none
module palette_pixel_window_writer_core
  import ppw_pkg::*;
#(
  parameter int PALETTE_DEPTH   = 256,
  parameter int MAX_LINE_PIXELS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_palette_index,
  input  wire logic [15:0] in_palette_color,
  input  wire logic [9:0]  in_window_x,
  input  wire logic [9:0]  in_window_y,
  input  wire logic [10:0] in_window_width,
  input  wire logic [10:0] in_window_height,
  input  wire logic [7:0]  in_packed_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_link_byte,
  output logic             out_is_data,
  output logic             out_end_of_line,
  output logic             out_end_of_window,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  cfg_t    cfg_r;
  logic    q_full, push, pop;
  entry_t  push_entry;
  q_head_t head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth  <= DEPTH_DIRECT;
      cfg_r.col_op <= COL_OP_RST;
      cfg_r.row_op <= ROW_OP_RST;
      cfg_r.mem_op <= MEM_OP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEPTH:  cfg_r.depth  <= cfg_data[2:0];
        REG_COL_OP: cfg_r.col_op <= cfg_data;
        REG_ROW_OP: cfg_r.row_op <= cfg_data;
        REG_MEM_OP: cfg_r.mem_op <= cfg_data;
        default:    cfg_r.depth  <= cfg_r.depth;
      endcase
    end
  end

  ppw_front #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_valid && !in_stall),
    .command       (in_command),
    .palette_index (in_palette_index),
    .palette_color (in_palette_color),
    .window_x      (in_window_x),
    .window_y      (in_window_y),
    .window_width  (in_window_width),
    .window_height (in_window_height),
    .packed_byte   (in_packed_byte),
    .cfg           (cfg_r),
    .push          (push),
    .push_entry    (push_entry)
  );

  ppw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head       (head)
  );

  ppw_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .cfg               (cfg_r),
    .pop               (pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_link_byte     (out_link_byte),
    .out_is_data       (out_is_data),
    .out_end_of_line   (out_end_of_line),
    .out_end_of_window (out_end_of_window),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/ppw_front.sv -----
// Front end: accepts input transactions, tracks line and window counters,
// and pushes classified work into the queue. Depends on ppw_pkg.
`default_nettype none
module ppw_front
  import ppw_pkg::*;
#(
  parameter int MAX_LINE_PIXELS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  palette_index,
  input  wire logic [15:0] palette_color,
  input  wire logic [9:0]  window_x,
  input  wire logic [9:0]  window_y,
  input  wire logic [10:0] window_width,
  input  wire logic [10:0] window_height,
  input  wire logic [7:0]  packed_byte,
  input  wire cfg_t        cfg,
  output logic             push,
  output entry_t           push_entry
);

  logic [CNT_W-1:0] lbc_r, lbc_nxt;
  logic [CNT_W-1:0] lc_r, lc_nxt;
  logic [CNT_W-1:0] bpl_r, bpl_nxt;
  logic [10:0]      liw_r, liw_nxt;
  logic [10:0]      ew;
  logic [CNT_W-1:0] inc;
  logic [CNT_W-1:0] lc_inc;

  always_comb begin
    if (32'(window_width) > MAX_LINE_PIXELS) ew = 11'(MAX_LINE_PIXELS);
    else ew = window_width;
  end

  always_comb begin
    lbc_nxt = lbc_r;
    lc_nxt  = lc_r;
    bpl_nxt = bpl_r;
    liw_nxt = liw_r;
    push    = 1'b0;
    inc     = lbc_r + 13'd1;
    lc_inc  = lc_r + 13'd1;

    push_entry.kind      = KIND_PAL;
    push_entry.depth     = cfg.depth;
    push_entry.eol       = 1'b0;
    push_entry.eow       = 1'b0;
    push_entry.pal_index = palette_index;
    push_entry.color     = palette_color;
    push_entry.x0        = window_x;
    push_entry.y0        = window_y;
    push_entry.x1        = 16'({6'd0, window_x}) + 16'({5'd0, window_width}) - 16'd1;
    push_entry.y1        = 16'({6'd0, window_y}) + 16'({5'd0, window_height}) - 16'd1;
    push_entry.pbyte     = packed_byte;

    case (command)
      CMD_PAL: begin
        push = accept;
      end
      CMD_WIN: begin
        push            = accept;
        push_entry.kind = KIND_HDR;
        if (accept) begin
          if (cfg.depth < DEPTH_DIRECT) bpl_nxt = 13'(ew >> (~cfg.depth[1:0]));
          else bpl_nxt = {1'b0, ew, 1'b0};
          liw_nxt = window_height;
          lbc_nxt = '0;
          lc_nxt  = '0;
        end
      end
      CMD_PIX: begin
        push_entry.kind = KIND_PIX;
        // bytes outside an open window are dropped here
        if (accept && bpl_r != '0 && lc_r < {2'b00, liw_r}) begin
          push = 1'b1;
          if (inc >= bpl_r) begin
            push_entry.eol = 1'b1;
            push_entry.eow = (lc_inc >= {2'b00, liw_r});
            lbc_nxt        = '0;
            lc_nxt         = lc_inc;
          end else begin
            lbc_nxt = inc;
          end
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbc_r <= '0;
      lc_r  <= '0;
      bpl_r <= '0;
      liw_r <= '0;
    end else begin
      lbc_r <= lbc_nxt;
      lc_r  <= lc_nxt;
      bpl_r <= bpl_nxt;
      liw_r <= liw_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ppw_queue.sv -----
// Short work queue between front and back ends.
// Depends on ppw_pkg for the entry type and depth.
`default_nettype none
module ppw_queue
  import ppw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output q_head_t     head
);

  localparam int CNTQ_W = QPTR_W + 1;

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [CNTQ_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNTQ_W'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CNTQ_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - CNTQ_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QPTR_W'(1);
      if (pop) rptr_r <= rptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ppw_back.sv -----
// Back end: unless stalled, steps through queued work one link byte per
// cycle, owns the palette memory and the output register. Depends on ppw_pkg.
`default_nettype none
module ppw_back
  import ppw_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_head_t head,
  input  wire cfg_t    cfg,
  output logic         pop,
  input  wire logic    out_stall,
  output logic         out_valid,
  output logic [7:0]   out_link_byte,
  output logic         out_is_data,
  output logic         out_end_of_line,
  output logic         out_end_of_window,
  output logic         out_last
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [15:0] pal_mem [PALETTE_DEPTH];
  logic [15:0] rd_r;

  logic [3:0] step_r, step_nxt;
  logic       ov_r;
  logic [7:0] ob_byte_r;
  logic       ob_data_r, ob_eol_r, ob_eow_r, ob_last_r;
  logic       ob_pal_r, ob_hi_r, ob_oor_r;

  entry_t     e;
  logic       adv, fire, op_valid, wr_en;
  logic [3:0] last_step;
  logic [2:0] pix, sh;
  logic [7:0] mask, idx;
  logic       oor;
  logic [AW-1:0] raddr, waddr;
  logic [7:0] op_byte;
  logic       op_data, op_eol, op_eow, op_last, op_pal, op_hi;

  assign e   = head.entry;
  assign adv = !ov_r || !out_stall;
  assign fire = adv && head.valid;

  always_comb begin
    case (e.kind)
      KIND_HDR: last_step = HDR_LAST_STEP;
      KIND_PIX: begin
        if (e.depth < DEPTH_DIRECT) last_step = 4'((5'd16 >> e.depth[1:0]) - 5'd1);
        else last_step = 4'd0;
      end
      default: last_step = 4'd0;
    endcase
  end

  // pixel index extraction, least significant pixel first
  always_comb begin
    pix = step_r[3:1];
    sh  = pix << e.depth[1:0];
    case (e.depth)
      3'd0:    mask = 8'h01;
      3'd1:    mask = 8'h03;
      3'd2:    mask = 8'h0F;
      default: mask = 8'hFF;
    endcase
    idx   = (e.pbyte >> sh) & mask;
    oor   = ({1'b0, idx} >= 9'(PALETTE_DEPTH));
    raddr = idx[AW-1:0];
    waddr = e.pal_index[AW-1:0];
  end

  always_comb begin
    pop      = fire && (step_r == last_step);
    step_nxt = step_r;
    if (fire) step_nxt = pop ? 4'd0 : step_r + 4'd1;
    wr_en    = fire && (e.kind == KIND_PAL) && ({1'b0, e.pal_index} < 9'(PALETTE_DEPTH));
    op_valid = fire && (e.kind != KIND_PAL);

    op_byte = e.pbyte;
    op_data = 1'b1;
    op_eol  = 1'b0;
    op_eow  = 1'b0;
    op_last = (step_r == last_step);
    op_pal  = 1'b0;
    op_hi   = !step_r[0];

    if (e.kind == KIND_HDR) begin
      op_data = !(step_r == HDR_COL_STEP || step_r == HDR_ROW_STEP ||
                  step_r == HDR_LAST_STEP);
      case (step_r)
        4'd0:    op_byte = cfg.col_op;
        4'd1:    op_byte = {6'd0, e.x0[9:8]};
        4'd2:    op_byte = e.x0[7:0];
        4'd3:    op_byte = e.x1[15:8];
        4'd4:    op_byte = e.x1[7:0];
        4'd5:    op_byte = cfg.row_op;
        4'd6:    op_byte = {6'd0, e.y0[9:8]};
        4'd7:    op_byte = e.y0[7:0];
        4'd8:    op_byte = e.y1[15:8];
        4'd9:    op_byte = e.y1[7:0];
        default: op_byte = cfg.mem_op;
      endcase
    end else if (e.kind == KIND_PIX) begin
      op_pal = (e.depth < DEPTH_DIRECT);
      op_eol = op_last && e.eol;
      op_eow = op_last && e.eow;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) pal_mem[waddr] <= e.color;
    if (adv) rd_r <= pal_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob_byte_r <= op_byte;
      ob_data_r <= op_data;
      ob_eol_r  <= op_eol;
      ob_eow_r  <= op_eow;
      ob_last_r <= op_last;
      ob_pal_r  <= op_pal;
      ob_hi_r   <= op_hi;
      ob_oor_r  <= oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (adv) ov_r <= op_valid;
    end
  end

  always_comb begin
    if (!ob_pal_r) out_link_byte = ob_byte_r;
    else if (ob_oor_r) out_link_byte = 8'd0;
    else if (ob_hi_r) out_link_byte = rd_r[15:8];
    else out_link_byte = rd_r[7:0];
  end

  assign out_valid         = ov_r;
  assign out_is_data       = ob_data_r;
  assign out_end_of_line   = ob_eol_r;
  assign out_end_of_window = ob_eow_r;
  assign out_last          = ob_last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/ppw_checker.sv -----
// Port-level checks for the palette pixel window writer, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module ppw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_link_byte,
  input wire logic       out_is_data,
  input wire logic       out_end_of_line,
  input wire logic       out_end_of_window,
  input wire logic       out_last
);

  // a stalled result transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_link_byte) &&
      $stable(out_last) && $stable(out_end_of_line))
    else $error("stalled output changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_window |-> out_end_of_line)
    else $error("window end without line end");

  // a line ends only on the final byte of a pixel transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_line |-> out_is_data && out_last)
    else $error("line end on a non-final or command byte");

  // header command bytes never carry frame flags
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data |-> !out_end_of_line && !out_end_of_window)
    else $error("command byte flagged as line or window end");

endmodule

bind palette_pixel_window_writer_core ppw_checker u_ppw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_link_byte     (out_link_byte),
  .out_is_data       (out_is_data),
  .out_end_of_line   (out_end_of_line),
  .out_end_of_window (out_end_of_window),
  .out_last          (out_last)
);
`default_nettype wire
